[rtl/tfk_pkg.sv]
package tfk_pkg;

  localparam int TRIG_ITERATIONS = 16;
  localparam int CORDIC_STEPS = (TRIG_ITERATIONS < 24) ? TRIG_ITERATIONS : 24;
  localparam int CW = 34;
  localparam int TRIG_LATENCY = CORDIC_STEPS + 2;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [15:0] SMALL_TRIG_LIMIT = 16'sd32;
  localparam logic [15:0] LINK_LENGTH_RESET = 16'd8192;

  localparam logic [1:0] REG_FIRST_LINK_LENGTH = 2'd0;
  localparam logic [1:0] REG_SECOND_LINK_LENGTH = 2'd1;

  typedef logic signed [15:0] trig_t;

  function automatic logic signed [CW-1:0] atan_at(input int i);
    logic signed [CW-1:0] a;
    unique case (i)
      0: a = 34'sd536870912;
      1: a = 34'sd316933406;
      2: a = 34'sd167458907;
      3: a = 34'sd85004756;
      4: a = 34'sd42667331;
      5: a = 34'sd21354465;
      6: a = 34'sd10679838;
      7: a = 34'sd5340245;
      8: a = 34'sd2670163;
      9: a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41722;
      15: a = 34'sd20861;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2608;
      19: a = 34'sd1304;
      20: a = 34'sd652;
      21: a = 34'sd326;
      22: a = 34'sd163;
      default: a = 34'sd81;
    endcase
    return a;
  endfunction

endpackage

[rtl/tfk_cordic.sv]
module tfk_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [15:0]         angle,
  output logic                out_valid,
  output tfk_pkg::trig_t      cos_q,
  output tfk_pkg::trig_t      sin_q
);

  localparam int N = tfk_pkg::CORDIC_STEPS;
  localparam int CW = tfk_pkg::CW;

  logic signed [CW-1:0] xs [0:N];
  logic signed [CW-1:0] ys [0:N];
  logic signed [CW-1:0] zs [0:N];
  logic                 fl [0:N];
  logic                 v  [0:N];

  logic        flip;
  logic [15:0] folded;

  assign flip = angle[15] ^ angle[14];
  assign folded = {angle[15] ^ flip, angle[14:0]};

  function automatic tfk_pkg::trig_t finish(input logic signed [CW-1:0] x, input logic neg);
    logic signed [CW-1:0] q;
    logic signed [CW-1:0] r;
    tfk_pkg::trig_t t;
    q = neg ? -x : x;
    r = (q + 34'sd16384) >>> 15;
    if (r > 34'sd32767) t = 16'sd32767;
    else if (r < -34'sd32768) t = -16'sd32768;
    else t = r[15:0];
    if (t <= tfk_pkg::SMALL_TRIG_LIMIT && t >= -tfk_pkg::SMALL_TRIG_LIMIT) t = '0;
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (en) v[0] <= in_valid;
    if (en) begin
      xs[0] <= tfk_pkg::CORDIC_GAIN;
      ys[0] <= '0;
      zs[0] <= CW'($signed({folded, 16'h0000}));
      fl[0] <= flip;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else if (en) v[i+1] <= v[i];
      if (en) begin
        fl[i+1] <= fl[i];
        if (!zs[i][CW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - tfk_pkg::atan_at(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + tfk_pkg::atan_at(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v[N];
    if (en) begin
      cos_q <= finish(xs[N], fl[N]);
      sin_q <= finish(ys[N], fl[N]);
    end
  end

endmodule

[rtl/tfk_kin.sv]
module tfk_kin (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  tfk_pkg::trig_t     c1,
  input  tfk_pkg::trig_t     s1,
  input  tfk_pkg::trig_t     c12,
  input  tfk_pkg::trig_t     s12,
  input  logic signed [15:0] w1,
  input  logic signed [15:0] w2,
  input  logic [15:0]        l1,
  input  logic [15:0]        l2,
  output logic               out_valid,
  output logic signed [17:0] tip_x,
  output logic signed [17:0] tip_y,
  output logic signed [19:0] tip_vx,
  output logic signed [19:0] tip_vy
);

  logic               p_valid, q_valid, r_valid;
  logic signed [32:0] px1, px2, py1, py2;
  logic signed [15:0] p_w1, p_w2, q_w1, q_w2;
  logic signed [33:0] sx, sy;
  logic signed [32:0] q_px2, q_py2;
  logic signed [17:0] q_x, q_y, r_x, r_y;
  logic signed [49:0] mx1, my1;
  logic signed [48:0] mx2, my2;

  function automatic logic signed [17:0] pos_out(input logic signed [33:0] s);
    logic signed [34:0] r;
    r = (35'(s) + 35'sd16384) >>> 15;
    if (r > 35'sd131071) return 18'sd131071;
    if (r < -35'sd131072) return -18'sd131072;
    return r[17:0];
  endfunction

  function automatic logic signed [19:0] vel_out(input logic signed [51:0] s);
    logic signed [51:0] r;
    r = (s + 52'sd268435456) >>> 29;
    if (r > 52'sd524287) return 20'sd524287;
    if (r < -52'sd524288) return -20'sd524288;
    return r[19:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      q_valid <= 1'b0;
      r_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid <= in_valid;
      q_valid <= p_valid;
      r_valid <= q_valid;
      out_valid <= r_valid;
    end
    if (en) begin
      px1 <= $signed({1'b0, l1}) * c1;
      px2 <= $signed({1'b0, l2}) * c12;
      py1 <= $signed({1'b0, l1}) * s1;
      py2 <= $signed({1'b0, l2}) * s12;
      p_w1 <= w1;
      p_w2 <= w2;

      sx <= 34'(px1) + 34'(px2);
      sy <= 34'(py1) + 34'(py2);
      q_x <= pos_out(34'(px1) + 34'(px2));
      q_y <= pos_out(34'(py1) + 34'(py2));
      q_px2 <= px2;
      q_py2 <= py2;
      q_w1 <= p_w1;
      q_w2 <= p_w2;

      mx1 <= sx * q_w1;
      my1 <= sy * q_w1;
      mx2 <= q_px2 * q_w2;
      my2 <= q_py2 * q_w2;
      r_x <= q_x;
      r_y <= q_y;

      tip_x <= r_x;
      tip_y <= r_y;
      tip_vx <= vel_out(-(52'(my1) + 52'(my2)));
      tip_vy <= vel_out(52'(mx1) + 52'(mx2));
    end
  end

endmodule

[rtl/two_link_arm_forward_kinematics_top.sv]
// Two-link planar arm forward kinematics. Each input word carries the shoulder and elbow
// binary angles and rates; each output word gives tip position (Q3.14 m) and velocity
// (Q9.10 m/s), saturated. One word enters per cycle and passes through the CORDIC
// pipeline, one step per stage, then four multiply/sum stages. The whole pipeline holds
// while an output word waits. The user must write link lengths (Q2.14) only while
// the block is idle, through cfg_we/cfg_index/cfg_data; the block does not enforce this.
module two_link_arm_forward_kinematics_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // shoulder_angle, elbow_angle, shoulder_rate, elbow_rate
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tip_x[17:0], tip_y[35:18], tip_vx[55:36], tip_vy[75:56], zero fill
  output logic [79:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int L = tfk_pkg::TRIG_LATENCY;

  logic        en;
  logic [15:0] first_link_length, second_link_length;
  logic [15:0] angle_sum;
  logic        c1_valid, c12_valid;
  tfk_pkg::trig_t c1, s1, c12, s12;
  logic signed [15:0] w1d [0:L-1];
  logic signed [15:0] w2d [0:L-1];
  logic signed [17:0] tip_x, tip_y;
  logic signed [19:0] tip_vx, tip_vy;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign angle_sum = s_tdata[15:0] + s_tdata[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      first_link_length <= tfk_pkg::LINK_LENGTH_RESET;
      second_link_length <= tfk_pkg::LINK_LENGTH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tfk_pkg::REG_FIRST_LINK_LENGTH) first_link_length <= cfg_data;
      if (cfg_index == tfk_pkg::REG_SECOND_LINK_LENGTH) second_link_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1d[0] <= s_tdata[47:32];
      w2d[0] <= s_tdata[63:48];
    end
  end

  for (genvar i = 1; i < L; i++) begin : g_rate
    always_ff @(posedge clk) begin
      if (en) begin
        w1d[i] <= w1d[i-1];
        w2d[i] <= w2d[i-1];
      end
    end
  end

  tfk_cordic u_trig_shoulder (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid), .angle(s_tdata[15:0]),
    .out_valid(c1_valid), .cos_q(c1), .sin_q(s1)
  );

  tfk_cordic u_trig_sum (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid), .angle(angle_sum),
    .out_valid(c12_valid), .cos_q(c12), .sin_q(s12)
  );

  tfk_kin u_kin (
    .clk(clk), .rst(rst), .en(en), .in_valid(c1_valid),
    .c1(c1), .s1(s1), .c12(c12), .s12(s12),
    .w1(w1d[L-1]), .w2(w2d[L-1]),
    .l1(first_link_length), .l2(second_link_length),
    .out_valid(m_tvalid),
    .tip_x(tip_x), .tip_y(tip_y), .tip_vx(tip_vx), .tip_vy(tip_vy)
  );

  assign m_tdata = {4'b0000, tip_vy, tip_vx, tip_y, tip_x};

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    c1_valid == c12_valid) else $error("trig lanes out of step");

  a_small_zeroed: assert property (@(posedge clk) disable iff (rst)
    c1_valid |-> (c1 == 16'sd0 || c1 > 16'sd32 || c1 < -16'sd32))
    else $error("small cosine not zeroed");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(c1) && $stable(c1_valid) && $stable(w1d[L-1]))
    else $error("pipeline moved during stall");

endmodule
